### hw/rtl/bbi2c_pkg.sv
package bbi2c_pkg;

  // sequencer phases, one pin tick per visit; PH_ACK_HIGH and PH_STOP_B wait one extra tick
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_START_C   = 4'd3,
    PH_TX_LOW    = 4'd4,
    PH_TX_HIGH   = 4'd5,
    PH_ACK_LOW   = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_STOP_A    = 4'd8,
    PH_STOP_B    = 4'd9,
    PH_RX_LOW    = 4'd10,
    PH_RX_HIGH   = 4'd11,
    PH_MACK_LOW  = 4'd12,
    PH_MACK_HIGH = 4'd13,
    PH_FINISH    = 4'd14
  } phase_t;

  // opcode values
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // one tick item: command fields and sampled sda
  typedef struct packed {
    logic       start_cmd;
    logic       opcode;
    logic [7:0] dev_address;
    logic [7:0] register_address;
    logic [3:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } tick_in_t;

  // pin levels and status for one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
  } tick_out_t;

endpackage

### hw/rtl/bitbang_i2c_register_master.sv
// Bit-banged I2C register master, advanced one pin-timing tick per item.
// Each item on the cmd channel (cmd_valid/cmd_ready) is one tick: it carries a
// command (taken only while idle) and the sampled SDA level. For every item
// exactly one result leaves on the res channel (res_valid/res_ready), giving
// the SCL level, SDA drive enable and level, a received byte with its strobe,
// a write data request and busy/done flags.
// The result of an item is registered at the edge that accepts it.
// Throughput is one item per cycle while the receiver takes results; the
// sequencer, payload and output registers are the only stored elements on the path.
// A new item is taken whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the result and
// stops the input side only while the register stays full.
// A write sends start, device address, register address and the data bytes
// (write_byte is sampled the tick after byte_request). A read sends both
// addresses, a stop, a repeated start and the read address, then clocks in
// the bytes, acknowledging all but the last.
// Reset puts the sequencer in idle and empties the output register.
module bitbang_i2c_register_master #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  bbi2c_pkg::tick_in_t  cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output bbi2c_pkg::tick_out_t res
);
  import bbi2c_pkg::*;

  // byte index counts up to the count plus one
  localparam int BW = $clog2(MAX_DATA_BYTES + 2);

  phase_t        phase, phase_next, ph;
  logic [2:0]    bit_index, bit_index_next;
  logic [BW-1:0] byte_index, byte_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic          tick_wait, tick_wait_next;
  logic          is_read, is_read_next;
  logic [7:0]    held_device, held_device_next;
  logic [7:0]    held_register, held_register_next;
  logic [BW-1:0] held_count, held_count_next;

  logic          fire;
  logic          capture;
  logic [BW-1:0] cnt_sat;
  logic [7:0]    tx_src;
  logic [7:0]    tx_byte;
  logic [7:0]    rx_shift;
  logic          more_tx;
  logic          mack_last;
  tick_out_t     res_next;

  // handshake: output register frees the input side
  assign cmd_ready = !res_valid || res_ready;
  assign fire      = cmd_valid && cmd_ready;

  // command capture on an idle tick
  assign capture = (phase == PH_IDLE) && cmd.start_cmd;
  assign cnt_sat = (cmd.byte_count > 4'(MAX_DATA_BYTES)) ? BW'(MAX_DATA_BYTES)
                                                        : BW'(cmd.byte_count);

  // effective state for this tick, after a possible capture
  logic [BW-1:0] bidx;
  logic          rd;
  logic [7:0]    hdev, hreg;
  logic [BW-1:0] hcnt;
  logic [2:0]    bit_cur;
  logic          wait_cur;
  always_comb begin
    if (capture) begin
      ph       = PH_START_A;
      bidx     = '0;
      rd       = cmd.opcode;
      hdev     = cmd.dev_address;
      hreg     = cmd.register_address;
      hcnt     = cnt_sat;
      bit_cur  = '0;
      wait_cur = 1'b0;
    end else begin
      ph       = phase;
      bidx     = byte_index;
      rd       = is_read;
      hdev     = held_device;
      hreg     = held_register;
      hcnt     = held_count;
      bit_cur  = bit_index;
      wait_cur = tick_wait;
    end
  end

  // byte to send and shared decisions
  always_comb begin
    if (bidx == BW'(0)) begin
      tx_src = hdev;
    end else if (bidx == BW'(1)) begin
      tx_src = hreg;
    end else if (rd == OP_READ) begin
      tx_src = hdev + 8'd1;
    end else begin
      tx_src = cmd.write_byte;
    end
  end

  assign tx_byte   = (bit_cur == 3'd0) ? tx_src : shift_byte;
  assign rx_shift  = {shift_byte[6:0], cmd.sda_in};
  assign more_tx   = (bidx <= hcnt);
  assign mack_last = ((bidx + BW'(1)) >= hcnt);

  // next state
  always_comb begin
    phase_next         = ph;
    bit_index_next     = bit_cur;
    byte_index_next    = bidx;
    shift_byte_next    = shift_byte;
    tick_wait_next     = wait_cur;
    is_read_next       = rd;
    held_device_next   = hdev;
    held_register_next = hreg;
    held_count_next    = hcnt;
    case (ph)
      PH_START_A: phase_next = PH_START_B;
      PH_START_B: phase_next = PH_START_C;
      PH_START_C: begin
        bit_index_next = '0;
        phase_next     = PH_TX_LOW;
      end
      PH_TX_LOW: begin
        shift_byte_next = tx_byte;
        phase_next      = PH_TX_HIGH;
      end
      PH_TX_HIGH: begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
        if (bit_cur == 3'd7) begin
          bit_index_next = '0;
          tick_wait_next = 1'b0;
          phase_next     = PH_ACK_LOW;
        end else begin
          bit_index_next = bit_cur + 3'd1;
          phase_next     = PH_TX_LOW;
        end
      end
      PH_ACK_LOW: phase_next = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (!wait_cur) begin
          tick_wait_next = 1'b1;
        end else begin
          tick_wait_next = 1'b0;
          if (rd == OP_WRITE) begin
            if (more_tx) begin
              byte_index_next = bidx + BW'(1);
              phase_next      = PH_TX_LOW;
            end else begin
              phase_next = PH_FINISH;
            end
          end else if (bidx == BW'(0)) begin
            byte_index_next = BW'(1);
            phase_next      = PH_TX_LOW;
          end else if (bidx == BW'(1)) begin
            phase_next = PH_STOP_A;
          end else if (hcnt != '0) begin
            byte_index_next = '0;
            bit_index_next  = '0;
            shift_byte_next = '0;
            phase_next      = PH_RX_LOW;
          end else begin
            phase_next = PH_FINISH;
          end
        end
      end
      PH_STOP_A: begin
        tick_wait_next = 1'b0;
        phase_next     = PH_STOP_B;
      end
      PH_STOP_B: begin
        if (!wait_cur) begin
          tick_wait_next = 1'b1;
        end else begin
          tick_wait_next  = 1'b0;
          byte_index_next = BW'(2);
          phase_next      = PH_START_A;
        end
      end
      PH_RX_LOW: phase_next = PH_RX_HIGH;
      PH_RX_HIGH: begin
        shift_byte_next = rx_shift;
        if (bit_cur == 3'd7) begin
          bit_index_next = '0;
          phase_next     = PH_MACK_LOW;
        end else begin
          bit_index_next = bit_cur + 3'd1;
          phase_next     = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: phase_next = PH_MACK_HIGH;
      PH_MACK_HIGH: begin
        if (!mack_last) begin
          byte_index_next = bidx + BW'(1);
          shift_byte_next = '0;
          phase_next      = PH_RX_LOW;
        end else begin
          phase_next = PH_FINISH;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // pin levels and status for this tick
  always_comb begin
    res_next              = '0;
    res_next.scl_level    = 1'b1;
    res_next.sda_drive    = 1'b1;
    res_next.sda_level    = 1'b1;
    res_next.busy_res     = 1'b1;
    case (ph)
      PH_START_A: res_next.scl_level = 1'b0;
      PH_START_B: ;
      PH_START_C: res_next.sda_level = 1'b0;
      PH_TX_LOW: begin
        res_next.scl_level = 1'b0;
        res_next.sda_level = tx_byte[7];
      end
      PH_TX_HIGH: res_next.sda_level = shift_byte[7];
      PH_ACK_LOW: begin
        res_next.scl_level = 1'b0;
        res_next.sda_drive = 1'b0;
        res_next.sda_level = 1'b0;
      end
      PH_ACK_HIGH: begin
        res_next.sda_drive    = 1'b0;
        res_next.sda_level    = 1'b0;
        res_next.byte_request = wait_cur && (rd == OP_WRITE) && more_tx &&
                                (bidx != BW'(0));
      end
      PH_STOP_A: res_next.sda_level = 1'b0;
      PH_STOP_B: ;
      PH_RX_LOW: begin
        res_next.scl_level = 1'b0;
        res_next.sda_drive = 1'b0;
        res_next.sda_level = 1'b0;
      end
      PH_RX_HIGH: begin
        res_next.sda_drive = 1'b0;
        res_next.sda_level = 1'b0;
        if (bit_cur == 3'd7) begin
          res_next.read_valid = 1'b1;
          res_next.read_byte  = rx_shift;
        end
      end
      PH_MACK_LOW: begin
        res_next.scl_level = 1'b0;
        res_next.sda_level = mack_last;
      end
      PH_MACK_HIGH: res_next.sda_level = mack_last;
      PH_FINISH: res_next.done_res = 1'b1;
      default: res_next.busy_res = 1'b0;
    endcase
  end

  // sequencer registers, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      byte_index    <= '0;
      tick_wait     <= 1'b0;
      is_read       <= 1'b0;
      held_count    <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      byte_index    <= byte_index_next;
      tick_wait     <= tick_wait_next;
      is_read       <= is_read_next;
      held_count    <= held_count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte    <= '0;
      held_device   <= '0;
      held_register <= '0;
    end else if (fire) begin
      shift_byte    <= shift_byte_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule
